@@ design/bspo_pkg.sv @@
// shared types and constants for the octal varint bit packer
`timescale 1ns / 1ps

package bspo_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_PUT_BITS   = 2'd0,
        OP_PUT_VARINT = 2'd1,
        OP_ALIGN      = 2'd2
    } t_op;

    localparam int unsigned MAX_WIDTH   = 64;
    localparam int unsigned VAR_DIGITS  = 10;
    localparam int unsigned VAR_BITS    = 4 * (VAR_DIGITS + 1);
    localparam int unsigned BUF_BITS    = MAX_WIDTH + 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value;
        logic [6:0]  width;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // normalised command between front and back
    typedef struct packed {
        logic        is_align;
        logic [63:0] value;
        logic [6:0]  width;
    } t_cmd;

    // queue status towards the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back status for checking
    typedef struct packed {
        logic [6:0] bit_count;
        logic       load;
    } t_back_stat;

endpackage

@@ design/bspo_front.sv @@
// front end: takes input items and turns them into plain bit-append commands
`timescale 1ns / 1ps

module bspo_front
    import bspo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [2:0]          digit [VAR_DIGITS:0];
    logic [3:0]          top;
    logic [VAR_BITS-1:0] var_word;
    logic [6:0]          var_width;
    logic                known_op;
    logic                r_seen;

    // accept whenever the queue has room, once ready has come up after reset
    assign o_ready = !i_q_stat.full && r_seen;

    // ready comes up in the cycle after reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    // octal digit split and leading digit search
    always_comb begin
        top = 4'd0;
        for (int k = 0; k <= VAR_DIGITS; k++) begin
            digit[k] = 3'(i_data.value[31:0] >> (3 * k));
        end
        for (int k = 1; k <= VAR_DIGITS; k++) begin
            if (digit[k] != 3'd0) begin
                top = 4'(k);
            end
        end
    end

    // varint groups, closing group carries the top bit
    always_comb begin
        var_word = '0;
        for (int k = 1; k <= VAR_DIGITS; k++) begin
            var_word[4*k +: 4] = {1'b0, digit[k]};
        end
        var_word[3:0] = {1'b1, digit[0]};
        var_width     = 7'({top, 2'b00}) + 7'd4;
    end

    // command build
    always_comb begin
        known_op       = 1'b1;
        o_cmd.is_align = 1'b0;
        o_cmd.value    = '0;
        o_cmd.width    = '0;
        case (i_data.operation)
            OP_PUT_BITS: begin
                o_cmd.value = i_data.value;
                o_cmd.width = (i_data.width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_data.width;
            end
            OP_PUT_VARINT: begin
                o_cmd.value = 64'(var_word);
                o_cmd.width = var_width;
            end
            OP_ALIGN: begin
                o_cmd.is_align = 1'b1;
            end
            default: begin
                known_op = 1'b0;
            end
        endcase
    end

    // unused operation code is taken and dropped
    assign o_push = i_valid && o_ready && known_op;

endmodule

@@ design/bspo_queue.sv @@
// two-entry command queue between front and back
`timescale 1ns / 1ps

module bspo_queue
    import bspo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output logic    o_valid,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, n_wp;
    logic [QUEUE_AW-1:0] r_rp, n_rp;
    logic [QUEUE_AW:0]   r_count, n_count;

    assign o_valid      = (r_count != '0);
    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // pointer and count update
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ design/bspo_back.sv @@
// back end: merges commands into the bit buffer and emits completed bytes
`timescale 1ns / 1ps

module bspo_back
    import bspo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_data,
    output t_back_stat o_stat
);

    logic [BUF_BITS-1:0] r_buf, n_buf;
    logic [6:0]          r_cnt, n_cnt;
    logic                emit;
    logic [BUF_BITS-1:0] buf_s;
    logic [6:0]          cnt_s;
    logic [2:0]          fill;
    logic [6:0]          w_eff;
    logic [63:0]         aligned;
    logic [BUF_BITS-1:0] place;

    // output straight from the buffer head
    assign o_valid            = (r_cnt >= 7'd8);
    assign o_data.out_byte    = r_buf[BUF_BITS-1 -: 8];
    assign o_data.last_of_run = (r_cnt < 7'd16);
    assign emit               = o_valid && i_ready;

    // buffer after this cycle's transfer
    assign buf_s = emit ? {r_buf[BUF_BITS-9:0], 8'b0} : r_buf;
    assign cnt_s = emit ? r_cnt - 7'd8 : r_cnt;
    assign fill  = cnt_s[2:0];

    // load a command once fewer than eight bits remain
    assign o_pop = i_cmd_valid && (cnt_s[6:3] == 4'd0);

    // bit count of the command, padding taken from the current fill
    always_comb begin
        if (i_cmd.is_align) begin
            w_eff = (fill == 3'd0) ? 7'd0 : 7'd8 - {4'd0, fill};
        end else begin
            w_eff = i_cmd.width;
        end
    end

    // left-align the new bits behind the partial byte
    assign aligned = i_cmd.is_align ? 64'd0 : (i_cmd.value << (7'(MAX_WIDTH) - w_eff));
    assign place   = {aligned, 8'b0} >> fill;

    always_comb begin
        n_buf = buf_s;
        n_cnt = cnt_s;
        if (o_pop) begin
            n_buf = {buf_s[BUF_BITS-1 -: 8], 64'b0} | place;
            n_cnt = {4'd0, fill} + w_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

    assign o_stat.bit_count = r_cnt;
    assign o_stat.load      = o_pop;

endmodule

@@ design/bit_stream_packer_octal_varint.sv @@
// top level of the msb-first bit packer with octal varint encoding
//
// input channel i_valid/o_ready/i_data carries one operation per transfer:
// put bits (low width bits of value, width saturating at 64), put varint
// (low 32 bits of value as 4-bit octal groups, closing group has bit 3 set)
// or align (zero pad to the byte boundary). the output channel
// o_valid/i_ready/o_data gives each completed byte, first bit in bit 7,
// with last_of_run set on the final byte an item produces.
// an item passes the front in its transfer cycle and is written into the
// queue; the back loads it once fewer than eight bits remain in the bit
// buffer, and its bytes leave from that buffer register. the back emits
// one byte per cycle while i_ready is high and loads the next command in
// the cycle the current one's last byte leaves, so an item holds the back
// until its bytes (eight at most) are out; the output byte rate is the
// limit. a two-entry queue lets input transfers go on while the receiver
// stalls; when the queue is full o_ready drops. items that complete no
// byte only update the partial byte. reset clears the partial byte, the
// fill count and the queue; o_ready rises in the cycle after reset ends.
`timescale 1ns / 1ps

module bit_stream_packer_octal_varint
    import bspo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic       push;
    t_cmd       front_cmd;
    t_q_stat    q_stat;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       pop;
    t_back_stat back_stat;

    // classify and encode
    bspo_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // decoupling queue
    bspo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // byte packing
    bspo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .o_stat      (back_stat)
    );

    // nothing on the output right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // buffer never holds more than a full command plus seven bits
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.bit_count <= 7'd71)
        else $error("bit buffer overflow");

    // a load only happens from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.load |-> !q_stat.empty)
        else $error("load from empty queue");

    // a byte not marked last has another whole byte behind it
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_of_run |-> back_stat.bit_count >= 7'd16)
        else $error("last_of_run missing");

endmodule
